/* hw/rtl/pkcs_pc_pkg.sv */
// Shared constants, codes and prefix tables for the signature pad checker.
// No dependencies; imported by the checker top level and its assertion module.
package pkcs_pc_pkg;

  localparam int DIGEST_BYTES    = 20;
  localparam int MAX_BLOCK_BYTES = 512;
  localparam int LONG_PREFIX_LEN = 15;
  localparam int SHORT_PREFIX_LEN = 13;
  localparam int MIN_BLOCK_LEN   = 40;

  localparam int POS_W   = 9;
  localparam int DIG_AW  = $clog2(DIGEST_BYTES);
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam int LONG_END  = DIGEST_BYTES + LONG_PREFIX_LEN;
  localparam int SHORT_END = DIGEST_BYTES + SHORT_PREFIX_LEN;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [1:0]       enc_t;

  localparam enc_t ENC_NONE  = 2'd0;
  localparam enc_t ENC_LONG  = 2'd1;
  localparam enc_t ENC_SHORT = 2'd2;

  localparam logic ACT_DIGEST = 1'b0;
  localparam logic ACT_BLOCK  = 1'b1;

  localparam logic REG_BLOCK_LEN = 1'b0;
  localparam pos_t BLOCK_LEN_RST = 9'd127;

  localparam logic [7:0] FILL_BYTE = 8'hff;
  localparam logic [7:0] MARK_BYTE = 8'h01;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // Reversed DigestInfo, 15-byte form
  function automatic logic [7:0] long_prefix_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0:  b = 8'h14;
      4'd1:  b = 8'h04;
      4'd2:  b = 8'h00;
      4'd3:  b = 8'h05;
      4'd4:  b = 8'h1a;
      4'd5:  b = 8'h02;
      4'd6:  b = 8'h03;
      4'd7:  b = 8'h0e;
      4'd8:  b = 8'h2b;
      4'd9:  b = 8'h05;
      4'd10: b = 8'h06;
      4'd11: b = 8'h09;
      4'd12: b = 8'h30;
      4'd13: b = 8'h21;
      4'd14: b = 8'h30;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Reversed DigestInfo, 13-byte form
  function automatic logic [7:0] short_prefix_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0:  b = 8'h14;
      4'd1:  b = 8'h04;
      4'd2:  b = 8'h1a;
      4'd3:  b = 8'h02;
      4'd4:  b = 8'h03;
      4'd5:  b = 8'h0e;
      4'd6:  b = 8'h2b;
      4'd7:  b = 8'h05;
      4'd8:  b = 8'h06;
      4'd9:  b = 8'h07;
      4'd10: b = 8'h30;
      4'd11: b = 8'h1f;
      4'd12: b = 8'h30;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/pkcs1_signature_pad_checker.sv */
// PKCS #1 v1.5 SHA-1 signature padding checker, byte-reversed block layout.
// Depends on pkcs_pc_pkg and pkcs_pc_ram (digest store).
//
// Usage:
//   Input channel (in_valid/in_stall): one item per byte. in_action = 0 loads
//   the next of 20 digest bytes (natural order), in_action = 1 presents the
//   next signature block byte, positions 0 up to block_len.
//   Result channel (out_valid/out_stall): one item per block, given for the
//   byte at position block_len: out_signature_ok and out_matched_encoding.
//   APB port: register 0 at byte address 0 is block_len (9 bits). Writing it
//   restarts the block; the stored digest is kept.
// Timing:
//   One input item per cycle, sustained while in_stall is low. The result is
//   registered in the output register, or in the skid register while the
//   output is held. The digest entry for the next position is read from the
//   digest RAM in advance; a digest write to the entry being read is forwarded.
// Reset: block state, digest load index and output channel clear; block_len
//   returns to 127; digest contents are undefined until loaded.
// Stall: a result held by out_stall sits in the output register; one more can
//   enter a skid register, and while that is full in_stall is high.
module pkcs1_signature_pad_checker
  import pkcs_pc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_signature_ok,
  output enc_t              out_matched_encoding,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  pos_t              block_len_r;
  pos_t              pos_r, pos_nxt;
  logic [DIG_AW-1:0] ld_idx_r, ld_idx_nxt;
  logic              dmatch_r, dmatch_nxt;
  logic              long_r, long_nxt;
  logic              short_r, short_nxt;
  logic [2:0]        fill_r, fill_nxt;
  logic              tail_r, tail_nxt;
  logic              fwd_hit_r;
  logic [7:0]        fwd_data_r;
  logic              out_valid_r, skid_valid_r;
  logic              out_ok_r, skid_ok_r;
  enc_t              out_enc_r, skid_enc_r;

  logic              cfg_wr, acc, dig_wr, blk, final_byte, produce, out_take;
  logic [DIG_AW-1:0] raddr;
  logic [7:0]        ram_rdata, dig_byte;
  logic              res_ok;
  enc_t              res_enc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BLOCK_LEN);
  assign prdata = (paddr[2] == REG_BLOCK_LEN) ? CFG_DW'(block_len_r) : '0;

  assign in_stall   = skid_valid_r;
  assign acc        = in_valid && !in_stall;
  assign dig_wr     = acc && (in_action == ACT_DIGEST);
  assign blk        = acc && (in_action == ACT_BLOCK);
  assign final_byte = pos_r == block_len_r;
  assign produce    = blk && final_byte;
  assign out_take   = out_valid_r && !out_stall;

  assign out_valid            = out_valid_r;
  assign out_signature_ok     = out_ok_r;
  assign out_matched_encoding = out_enc_r;

  pkcs_pc_ram #(.WIDTH(8), .DEPTH(DIGEST_BYTES)) u_digest (
    .clk   (clk),
    .we    (dig_wr),
    .waddr (ld_idx_r),
    .wdata (in_data_byte),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign dig_byte = fwd_hit_r ? fwd_data_r : ram_rdata;

  always_comb begin
    logic [POS_W:0] p1;
    logic [3:0]     pidx;
    logic           ok_fill;
    logic           sel_long, sel_short;

    p1   = {1'b0, pos_r} + 1'b1;
    pidx = 4'(pos_r - POS_W'(DIGEST_BYTES));

    dmatch_nxt = dmatch_r;
    long_nxt   = long_r;
    short_nxt  = short_r;
    fill_nxt   = fill_r;
    tail_nxt   = tail_r;

    if (pos_r < POS_W'(DIGEST_BYTES) && in_data_byte != dig_byte) begin
      dmatch_nxt = 1'b0;
    end
    if (pos_r >= POS_W'(DIGEST_BYTES) && pos_r < POS_W'(LONG_END) &&
        in_data_byte != long_prefix_byte(pidx)) begin
      long_nxt = 1'b0;
    end
    if (pos_r >= POS_W'(DIGEST_BYTES) && pos_r < POS_W'(SHORT_END) &&
        in_data_byte != short_prefix_byte(pidx)) begin
      short_nxt = 1'b0;
    end
    // bit 0 long, bit 1 short, bit 2 no prefix
    if (pos_r == POS_W'(LONG_END)) begin
      if (in_data_byte != ZERO_BYTE) fill_nxt[0] = 1'b0;
    end else if (pos_r > POS_W'(LONG_END) && p1 < {1'b0, block_len_r}) begin
      if (in_data_byte != FILL_BYTE) fill_nxt[0] = 1'b0;
    end
    if (pos_r == POS_W'(SHORT_END)) begin
      if (in_data_byte != ZERO_BYTE) fill_nxt[1] = 1'b0;
    end else if (pos_r > POS_W'(SHORT_END) && p1 < {1'b0, block_len_r}) begin
      if (in_data_byte != FILL_BYTE) fill_nxt[1] = 1'b0;
    end
    if (pos_r == POS_W'(DIGEST_BYTES)) begin
      if (in_data_byte != ZERO_BYTE) fill_nxt[2] = 1'b0;
    end else if (pos_r > POS_W'(DIGEST_BYTES) && p1 < {1'b0, block_len_r}) begin
      if (in_data_byte != FILL_BYTE) fill_nxt[2] = 1'b0;
    end
    if (p1 == {1'b0, block_len_r} && in_data_byte != MARK_BYTE) tail_nxt = 1'b0;
    if (final_byte && in_data_byte != ZERO_BYTE) tail_nxt = 1'b0;

    sel_long  = long_nxt;
    sel_short = !long_nxt && short_nxt;
    ok_fill   = sel_long ? fill_nxt[0] : (sel_short ? fill_nxt[1] : fill_nxt[2]);
    res_ok    = dmatch_nxt && tail_nxt && ok_fill &&
                block_len_r >= POS_W'(MIN_BLOCK_LEN) &&
                {1'b0, block_len_r} <= (POS_W+1)'(MAX_BLOCK_BYTES - 1);
    if (!res_ok) begin
      res_enc = ENC_NONE;
    end else if (sel_long) begin
      res_enc = ENC_LONG;
    end else if (sel_short) begin
      res_enc = ENC_SHORT;
    end else begin
      res_enc = ENC_NONE;
    end

    if (cfg_wr) begin
      pos_nxt = '0;
    end else if (blk) begin
      pos_nxt = final_byte ? '0 : p1[POS_W-1:0];
    end else begin
      pos_nxt = pos_r;
    end

    if (pos_nxt < POS_W'(DIGEST_BYTES)) begin
      raddr = DIG_AW'(DIGEST_BYTES - 1) - pos_nxt[DIG_AW-1:0];
    end else begin
      raddr = '0;
    end

    if (produce) begin
      ld_idx_nxt = '0;
    end else if (dig_wr) begin
      ld_idx_nxt = (ld_idx_r == DIG_AW'(DIGEST_BYTES - 1)) ? '0 : ld_idx_r + 1'b1;
    end else begin
      ld_idx_nxt = ld_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= in_data_byte;
    if (!rst_n) begin
      block_len_r  <= BLOCK_LEN_RST;
      pos_r        <= '0;
      ld_idx_r     <= '0;
      dmatch_r     <= 1'b1;
      long_r       <= 1'b1;
      short_r      <= 1'b1;
      fill_r       <= 3'b111;
      tail_r       <= 1'b1;
      fwd_hit_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      ld_idx_r  <= ld_idx_nxt;
      fwd_hit_r <= dig_wr && (ld_idx_r == raddr);
      if (cfg_wr) begin
        block_len_r <= pwdata[POS_W-1:0];
      end
      if (cfg_wr || produce) begin
        dmatch_r <= 1'b1;
        long_r   <= 1'b1;
        short_r  <= 1'b1;
        fill_r   <= 3'b111;
        tail_r   <= 1'b1;
      end else if (blk) begin
        dmatch_r <= dmatch_nxt;
        long_r   <= long_nxt;
        short_r  <= short_nxt;
        fill_r   <= fill_nxt;
        tail_r   <= tail_nxt;
      end

      if (skid_valid_r) begin
        if (out_take) begin
          out_ok_r     <= skid_ok_r;
          out_enc_r    <= skid_enc_r;
          skid_valid_r <= 1'b0;
        end
      end else if (produce) begin
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
          out_ok_r    <= res_ok;
          out_enc_r   <= res_enc;
        end else begin
          skid_valid_r <= 1'b1;
          skid_ok_r    <= res_ok;
          skid_enc_r   <= res_enc;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/pkcs_pc_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module pkcs_pc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/pkcs_pc_checks.sv */
// Port-level assertions for the signature pad checker, bound to the top level.
// Depends on pkcs_pc_pkg and pkcs1_signature_pad_checker.
module pkcs_pc_checks
  import pkcs_pc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_signature_ok,
  input enc_t out_matched_encoding
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_signature_ok) &&
      $stable(out_matched_encoding))
    else $error("stalled result changed");

  a_fail_no_enc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_signature_ok |-> out_matched_encoding == ENC_NONE)
    else $error("encoding reported on failed check");

  a_enc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_matched_encoding == ENC_NONE ||
      out_matched_encoding == ENC_LONG || out_matched_encoding == ENC_SHORT)
    else $error("bad encoding code");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind pkcs1_signature_pad_checker pkcs_pc_checks u_checks (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_signature_ok     (out_signature_ok),
  .out_matched_encoding (out_matched_encoding)
);
